>>> hw/rtl/dwm_pkg.sv
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared types, register indexes and constants of the drowsiness window monitor.
// ----------------------------------------------------------------------------
package dwm_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_EAR_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_LIMIT    = 3'd4;

	localparam logic [15:0] EAR_THRESHOLD_RST = 16'd6554;
	localparam logic [15:0] WINDOW_MS_RST     = 16'd1500;
	localparam logic [15:0] WARMUP_MS_RST     = 16'd1500;
	localparam logic [9:0]  DROP_STEP_RST     = 10'd10;
	localparam logic [7:0]  DROP_LIMIT_RST    = 8'd2;

	localparam logic [7:0]  DROP_COUNT_MAX    = 8'd255;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// window entry: time stamp and closed bit
	localparam int ENTRY_W = 33;

	typedef struct packed {
		logic [15:0] ear_threshold;
		logic [15:0] window_ms;
		logic [15:0] warmup_ms;
		logic [9:0]  drop_step;
		logic [7:0]  drop_limit;
	} dwm_cfg_t;

	typedef struct packed {
		logic [31:0]        time_ms;
		logic               face_present;
		logic [15:0]        ear_left;
		logic [15:0]        ear_right;
		logic signed [11:0] face_top;
		logic signed [11:0] face_bottom;
	} dwm_in_t;

	typedef struct packed {
		logic [16:0] closed_ratio;
		logic        eyes_closed;
		logic        head_dropped;
		logic        window_overflow;
	} dwm_out_t;

	// classified frame handed from front to back
	typedef struct packed {
		logic [31:0] time_ms;
		logic        stored;
		logic        eyes_closed;
		logic        head_dropped;
	} dwm_job_t;

endpackage

>>> hw/rtl/dwm_ram.sv
// ----------------------------------------------------------------------------
// dwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/dwm_front.sv
// ----------------------------------------------------------------------------
// dwm_front
// Accepts frames, judges eye closure and tracks the head-drop count.
// ----------------------------------------------------------------------------
module dwm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  dwm_pkg::dwm_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  dwm_pkg::dwm_in_t  in_data,
	input  logic              q_full,
	output logic              push,
	output dwm_pkg::dwm_job_t job
);
	import dwm_pkg::*;

	logic signed [12:0] prev_sum_q;
	logic               prev_valid_q;
	logic [7:0]         drop_count_q;

	logic signed [12:0] sum;
	logic signed [13:0] diff;
	logic signed [13:0] step2;
	logic [16:0]        ear_sum;
	logic               closed;
	logic [7:0]         drop_next;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign sum     = $signed({in_data.face_top[11], in_data.face_top})
	               + $signed({in_data.face_bottom[11], in_data.face_bottom});
	assign diff    = $signed({sum[12], sum}) - $signed({prev_sum_q[12], prev_sum_q});
	assign step2   = $signed({3'b000, cfg.drop_step, 1'b0});
	assign ear_sum = {1'b0, in_data.ear_left} + {1'b0, in_data.ear_right};
	// mean below threshold, kept exact by comparing against twice the threshold
	assign closed  = in_data.face_present && (ear_sum < {cfg.ear_threshold, 1'b0});

	always_comb begin
		drop_next = drop_count_q;
		if (in_data.face_present) begin
			if (!prev_valid_q) begin
				drop_next = '0;
			end else if ((diff > step2) && closed) begin
				if (drop_count_q != DROP_COUNT_MAX) begin
					drop_next = drop_count_q + 8'd1;
				end
			end else if (diff[13]) begin
				drop_next = '0;
			end
		end
	end

	always_comb begin
		job.time_ms      = in_data.time_ms;
		job.eyes_closed  = closed;
		job.stored       = closed && (in_data.time_ms > {16'd0, cfg.warmup_ms});
		job.head_dropped = (drop_next >= cfg.drop_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sum_q   <= '0;
			prev_valid_q <= 1'b0;
			drop_count_q <= '0;
		end else if (push && in_data.face_present) begin
			prev_sum_q   <= sum;
			prev_valid_q <= 1'b1;
			drop_count_q <= drop_next;
		end
	end

endmodule

>>> hw/rtl/dwm_queue.sv
// ----------------------------------------------------------------------------
// dwm_queue
// Short FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module dwm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dwm_pkg::dwm_job_t wr_job,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output dwm_pkg::dwm_job_t rd_job
);
	import dwm_pkg::*;

	dwm_job_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full   = (count_q == Q_CNT_W'(Q_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/dwm_back.sv
// ----------------------------------------------------------------------------
// dwm_back
// Time window FIFO: push, overflow drop, age eviction and closed-ratio divide.
// ----------------------------------------------------------------------------
module dwm_back #(
	parameter int WINDOW_DEPTH = dwm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       window_ms,
	input  logic              q_valid,
	input  dwm_pkg::dwm_job_t q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output dwm_pkg::dwm_out_t out_data
);
	import dwm_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int QW    = CNT_W + 16;
	localparam int ITR_W = $clog2(QW);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OVF,
		S_PUSH,
		S_EVRD,
		S_EVCHK,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;
	dwm_job_t         job_q;
	logic             ovf_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] entries_q;
	logic [CNT_W-1:0] total_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [ITR_W-1:0] itr_q;
	logic             out_valid_q;
	dwm_out_t         out_q;

	logic [CNT_W:0]       slot_sum;
	logic [PTR_W-1:0]     slot;
	logic [PTR_W-1:0]     head_inc;
	logic [ENTRY_W-1:0]   rdata;
	logic [31:0]          age;
	logic                 too_old;
	logic [CNT_W:0]       rem_sh;
	logic [CNT_W:0]       rem_sub;
	logic                 rem_ge;
	logic [CNT_W-1:0]     total_pop;

	assign slot_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(entries_q);
	assign slot     = (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH))
	                ? PTR_W'(slot_sum - (CNT_W+1)'(WINDOW_DEPTH))
	                : slot_sum[PTR_W-1:0];
	assign head_inc = (head_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// closed count after dropping the oldest entry
	assign total_pop = (rdata[0] && (total_q != '0)) ? total_q - 1'b1 : total_q;

	// wrapping age so stamps from the future look very old
	assign age     = job_q.time_ms - rdata[ENTRY_W-1:1];
	assign too_old = (entries_q != '0) && (age > {16'd0, window_ms});

	assign rem_sh  = {rem_q, quo_q[QW-1]};
	assign rem_ge  = (rem_sh >= {1'b0, entries_q});
	assign rem_sub = rem_sh - {1'b0, entries_q};

	assign q_pop = (state_q == S_IDLE) && q_valid;

	dwm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (state_q == S_PUSH),
		.waddr (slot),
		.wdata ({job_q.time_ms, job_q.stored}),
		.raddr (head_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= '0;
			ovf_q       <= 1'b0;
			head_q      <= '0;
			entries_q   <= '0;
			total_q     <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			itr_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// drop the taken beat unless a new one is loaded below
			if (out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						job_q   <= q_job;
						ovf_q   <= (entries_q == CNT_W'(WINDOW_DEPTH));
						state_q <= (entries_q == CNT_W'(WINDOW_DEPTH)) ? S_OVF : S_PUSH;
					end
				end
				S_OVF: begin
					// read of the head was issued while idle
					total_q   <= total_pop;
					head_q    <= head_inc;
					entries_q <= entries_q - 1'b1;
					state_q   <= S_PUSH;
				end
				S_PUSH: begin
					entries_q <= entries_q + 1'b1;
					if (job_q.stored) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_EVRD;
				end
				S_EVRD: begin
					state_q <= S_EVCHK;
				end
				S_EVCHK: begin
					if (too_old) begin
						total_q   <= total_pop;
						head_q    <= head_inc;
						entries_q <= entries_q - 1'b1;
						state_q   <= S_EVRD;
					end else begin
						quo_q   <= {total_q, 16'd0};
						rem_q   <= '0;
						itr_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
					quo_q <= {quo_q[QW-2:0], rem_ge};
					itr_q <= itr_q + 1'b1;
					if (itr_q == ITR_W'(QW - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.closed_ratio    <= (entries_q == '0) ? '0 : quo_q[16:0];
						out_q.eyes_closed     <= job_q.eyes_closed;
						out_q.head_dropped    <= job_q.head_dropped;
						out_q.window_overflow <= ovf_q;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window entry count above depth");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= entries_q)
		else $error("closed count above entry count");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH) |-> (entries_q != CNT_W'(WINDOW_DEPTH)))
		else $error("push into a full window");

	a_newest_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVRD) |-> (entries_q != '0))
		else $error("eviction removed the frame just pushed");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (quo_q[QW-1:17] == '0))
		else $error("closed ratio above one");

endmodule

>>> hw/rtl/drowsiness_window_monitor.sv
// ----------------------------------------------------------------------------
// drowsiness_window_monitor
// Per-frame eye-closure ratio over a time window and head-drop alarm.
// ----------------------------------------------------------------------------
// One input beat per video frame gives one output beat. The front judges the
// frame in the cycle it is accepted and parks it in a two-entry queue, so the
// next frames are taken while the back is busy. The back handles one frame at
// a time, and a full window first drops its oldest entry. The time the back
// spends on a frame is set by the bit-serial divider for the closed ratio and
// by the eviction loop, which evicts entries for age one by one over the window
// RAM's single read port. Configuration writes take effect at once and belong
// to idle periods.
module drowsiness_window_monitor #(
	parameter int WINDOW_DEPTH = dwm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dwm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dwm_pkg::dwm_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dwm_pkg::dwm_out_t              out_data
);
	import dwm_pkg::*;

	dwm_cfg_t cfg_q;
	dwm_job_t push_job;
	dwm_job_t pop_job;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ear_threshold <= EAR_THRESHOLD_RST;
			cfg_q.window_ms     <= WINDOW_MS_RST;
			cfg_q.warmup_ms     <= WARMUP_MS_RST;
			cfg_q.drop_step     <= DROP_STEP_RST;
			cfg_q.drop_limit    <= DROP_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EAR_THRESHOLD: cfg_q.ear_threshold <= cfg_wdata;
				CFG_WINDOW_MS:     cfg_q.window_ms     <= cfg_wdata;
				CFG_WARMUP_MS:     cfg_q.warmup_ms     <= cfg_wdata;
				CFG_DROP_STEP:     cfg_q.drop_step     <= cfg_wdata[9:0];
				CFG_DROP_LIMIT:    cfg_q.drop_limit    <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	dwm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	dwm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.full   (q_full),
		.valid  (q_valid),
		.rd_job (pop_job)
	);

	dwm_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.window_ms (cfg_q.window_ms),
		.q_valid   (q_valid),
		.q_job     (pop_job),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
